[hdl/isc_pkg.sv]
// isc_pkg: shared sizes, key type and inter-module structs for the
// counted insertion sorter. No dependencies.
package isc_pkg;

    localparam int DEPTH = 64;
    localparam int KEY_W = 32;
    localparam int CNT_W = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic signed [KEY_W-1:0] t_key;

    // what one cell shows its neighbors
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    valid;
        logic                    smaller;  // valid and key strictly below new key
    } t_link;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;  // insert the broadcast key
        logic shl;  // shift toward cell 0 (drain)
    } t_cell_ctl;

    // registered insertion result for the counter stage
    typedef struct packed {
        logic             valid;  // a counted insertion happened
        logic [DEPTH-1:0] bound;  // one-hot insertion position
    } t_upd;

endpackage

[hdl/isc_cell.sv]
// isc_cell: one slot of the sorted chain. Holds a key and a valid bit,
// compares against the broadcast key and trades data with its neighbors. Uses isc_pkg.
module isc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isc_pkg::t_cell_ctl  i_ctl,
    input  isc_pkg::t_key       i_new_key,
    input  isc_pkg::t_link      i_left,
    input  isc_pkg::t_link      i_right,
    output isc_pkg::t_link      o_link
);

    isc_pkg::t_key r_key;
    isc_pkg::t_key n_key;
    logic          r_valid;
    logic          n_valid;
    logic          w_smaller;

    assign w_smaller = r_valid && (r_key < i_new_key);

    // insert: keep if smaller, take new key at the boundary, else shift right
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (!w_smaller) begin
                if (i_left.smaller) begin
                    n_key   = i_new_key;
                    n_valid = 1'b1;
                end else begin
                    n_key   = i_left.key;
                    n_valid = i_left.valid;
                end
            end
        end else if (i_ctl.shl) begin
            n_key   = i_right.key;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_link.key     = r_key;
    assign o_link.valid   = r_valid;
    assign o_link.smaller = w_smaller;

endmodule

[hdl/isc_count.sv]
// isc_count: compare and move counters. Encodes the registered insertion
// position and adds it with saturation. Uses isc_pkg.
module isc_count (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isc_pkg::t_upd                 i_upd,
    input  logic                          i_clear,
    output logic [isc_pkg::CNT_W-1:0]     o_compare_total,
    output logic [isc_pkg::CNT_W-1:0]     o_move_total
);

    logic [isc_pkg::CNT_W-1:0] r_cmp;
    logic [isc_pkg::CNT_W-1:0] n_cmp;
    logic [isc_pkg::CNT_W-1:0] r_mov;
    logic [isc_pkg::CNT_W-1:0] n_mov;
    logic [isc_pkg::IDX_W-1:0] w_idx;
    logic [isc_pkg::CNT_W:0]   w_cmp_sum;
    logic [isc_pkg::CNT_W:0]   w_mov_sum;

    // one-hot to index: OR of the set positions
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < isc_pkg::DEPTH; i++) begin
            if (i_upd.bound[i]) begin
                w_idx = w_idx | isc_pkg::IDX_W'(i);
            end
        end
    end

    // compares add 1 + c, moves add 3 + c
    assign w_cmp_sum = {1'b0, r_cmp} + (isc_pkg::CNT_W + 1)'(w_idx)
                     + (isc_pkg::CNT_W + 1)'(1);
    assign w_mov_sum = {1'b0, r_mov} + (isc_pkg::CNT_W + 1)'(w_idx)
                     + (isc_pkg::CNT_W + 1)'(3);

    always_comb begin
        n_cmp = r_cmp;
        n_mov = r_mov;
        if (i_clear) begin
            n_cmp = '0;
            n_mov = '0;
        end else if (i_upd.valid) begin
            n_cmp = w_cmp_sum[isc_pkg::CNT_W] ? isc_pkg::CNT_MAX
                                              : w_cmp_sum[isc_pkg::CNT_W-1:0];
            n_mov = w_mov_sum[isc_pkg::CNT_W] ? isc_pkg::CNT_MAX
                                              : w_mov_sum[isc_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp <= '0;
            r_mov <= '0;
        end else begin
            r_cmp <= n_cmp;
            r_mov <= n_mov;
        end
    end

    assign o_compare_total = r_cmp;
    assign o_move_total    = r_mov;

endmodule

[hdl/insertion_sort_counted.sv]
// insertion_sort_counted: top level of the counted insertion sorter.
// Depends on isc_pkg, isc_cell and isc_count.
//
// Usage:
//   Input channel (i_valid/o_ready, see ports): one key per beat, i_last
//   marks the final key of a set. Keys are Q16.16 two's complement.
//   Each beat enters a row of DEPTH cells; every cell compares the new key
//   at once and the row shifts right past the insertion point, so a key is
//   taken every cycle while loading.
//   A key arriving with all DEPTH cells full is dropped and counts nothing;
//   its last mark still ends the set.
//   After the last beat the input stalls and the row drains toward cell 0,
//   one sorted key per cycle through the output register, ascending, while
//   the receiver does not stall. The beat with o_final_res high carries the
//   compare and move totals (others carry 0).
//   Loading resumes in the cycle after the final beat is produced, even
//   while that beat still waits in the output register.
//   Receiver stalls (o_valid high, i_ready low) freeze the drain; the output
//   holds its beat. Reset (synchronous, active low) empties the row, clears
//   the counters and leaves the output channel idle. No clearing pass.
module insertion_sort_counted (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_key,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_sorted_key,
    output logic                          o_final_res,
    output logic [15:0]                   o_compare_total,
    output logic [15:0]                   o_move_total
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic r_state;
    logic n_state;

    isc_pkg::t_link    w_link [isc_pkg::DEPTH];
    isc_pkg::t_link    w_tie_left;
    isc_pkg::t_link    w_tie_right;
    isc_pkg::t_cell_ctl w_ctl;
    isc_pkg::t_upd     r_upd;
    isc_pkg::t_upd     n_upd;

    logic w_accept;
    logic w_full;
    logic w_pop;
    logic w_pop_final;

    logic [isc_pkg::CNT_W-1:0] w_cmp;
    logic [isc_pkg::CNT_W-1:0] w_mov;

    logic                       r_o_valid;
    isc_pkg::t_key              r_o_key;
    logic                       r_o_final;
    logic [isc_pkg::CNT_W-1:0]  r_o_cmp;
    logic [isc_pkg::CNT_W-1:0]  r_o_mov;

    // handshake and control
    assign o_ready     = (r_state == ST_LOAD);
    assign w_accept    = i_valid && o_ready;
    assign w_full      = w_link[isc_pkg::DEPTH-1].valid;
    assign w_pop       = (r_state == ST_DRAIN) && (!r_o_valid || i_ready);
    assign w_pop_final = w_pop && !w_link[1].valid;

    assign w_ctl.ins = w_accept && !w_full;
    assign w_ctl.shl = w_pop;

    // chain ends: cell 0 always sees a smaller left neighbor
    assign w_tie_left.key      = '0;
    assign w_tie_left.valid    = 1'b1;
    assign w_tie_left.smaller  = 1'b1;
    assign w_tie_right.key     = '0;
    assign w_tie_right.valid   = 1'b0;
    assign w_tie_right.smaller = 1'b0;

    // the cell row
    for (genvar g = 0; g < isc_pkg::DEPTH; g++) begin : g_cell
        isc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new_key (i_key),
            .i_left    ((g == 0) ? w_tie_left : w_link[(g == 0) ? 0 : g - 1]),
            .i_right   ((g == isc_pkg::DEPTH - 1) ? w_tie_right
                        : w_link[(g == isc_pkg::DEPTH - 1) ? g : g + 1]),
            .o_link    (w_link[g])
        );
    end

    // insertion point: first cell not smaller, after a smaller one
    always_comb begin
        n_upd.valid = w_ctl.ins && w_link[0].valid;
        for (int i = 0; i < isc_pkg::DEPTH; i++) begin
            n_upd.bound[i] = !w_link[i].smaller
                           && ((i == 0) ? 1'b1 : w_link[(i == 0) ? 0 : i - 1].smaller);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd.valid <= 1'b0;
        end else begin
            r_upd.valid <= n_upd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upd.bound <= n_upd.bound;
    end

    isc_count u_count (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_upd           (r_upd),
        .i_clear         (w_pop_final),
        .o_compare_total (w_cmp),
        .o_move_total    (w_mov)
    );

    // load / drain sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_pop_final) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_o_key   <= w_link[0].key;
            r_o_final <= !w_link[1].valid;
            r_o_cmp   <= w_link[1].valid ? '0 : w_cmp;
            r_o_mov   <= w_link[1].valid ? '0 : w_mov;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_sorted_key    = r_o_key;
    assign o_final_res     = r_o_final;
    assign o_compare_total = r_o_cmp;
    assign o_move_total    = r_o_mov;

endmodule

[hdl/isc_checker.sv]
// isc_port_checks: port-level checks for insertion_sort_counted, bound to the
// top level. No package dependency.
module isc_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_last,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_sorted_key,
    input logic               o_final_res,
    input logic [15:0]        o_compare_total,
    input logic [15:0]        o_move_total
);

    // a stalled output beat holds its key
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sorted_key))
        else $error("output beat changed while stalled");

    // totals are only shown on the final beat
    a_totals_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> o_compare_total == 16'd0 && o_move_total == 16'd0)
        else $error("totals on a non-final beat");

    // no loading while a run is still draining
    a_no_load_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> !o_ready)
        else $error("input open during drain");

    // the accepted last key closes the input
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last |=> !o_ready)
        else $error("input still open after last key");

    // a taken non-final beat is followed at once by the next one
    a_drain_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_final_res |=> o_valid)
        else $error("gap inside a drain");

endmodule

bind insertion_sort_counted isc_port_checks u_isc_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_last          (i_last),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_sorted_key    (o_sorted_key),
    .o_final_res     (o_final_res),
    .o_compare_total (o_compare_total),
    .o_move_total    (o_move_total)
);
